>>> rtl/rfep_pkg.sv
// Shared types, constants and constant functions of the root fraction profile core.
package rfep_pkg;

    // Fixed-point formats.
    localparam int FRAC_BITS  = 16;
    localparam int DEPTH_BITS = 16;
    localparam int LOG_FRAC   = 24;
    localparam int DIV_STEPS  = FRAC_BITS;

    localparam logic [32:0] ONE_Q32   = 33'h1_0000_0000;
    localparam logic [16:0] SHARE_ONE = 17'h1_0000;

    // Input transfer payload.
    typedef struct packed {
        logic [FRAC_BITS-1:0]  root_coeff;
        logic [DEPTH_BITS-1:0] top_depth;
        logic [DEPTH_BITS-1:0] mid_depth;
        logic [DEPTH_BITS-1:0] low_depth;
    } rfep_in_t;

    // Result transfer payload.
    typedef struct packed {
        logic [16:0] share_top;
        logic [16:0] share_mid;
        logic [16:0] share_low;
        logic        degenerate;
    } rfep_out_t;

    // Logarithm stages: squaring iterations on the normalized coefficient.
    typedef struct packed {
        logic [15:0] dep_a;
        logic [16:0] dep_b;
        logic [17:0] dep_c;
        logic        coeff_zero;
        logic [3:0]  msb;
        logic [30:0] x;
        logic [23:0] q;
    } log_stage_t;

    // Finished negative logarithm with the depth sums.
    typedef struct packed {
        logic [15:0] dep_a;
        logic [16:0] dep_b;
        logic [17:0] dep_c;
        logic        coeff_zero;
        logic [28:0] neg_log;
    } lgt_stage_t;

    // Exponential stages, three lanes for the three cumulative depths.
    typedef struct packed {
        logic [2:0][32:0] acc;
        logic [2:0][23:0] frac;
        logic [2:0][5:0]  shift;
        logic [2:0]       force_one;
        logic [2:0]       force_zero;
    } exp_stage_t;

    // Cumulative shares c1, c12 and c123.
    typedef struct packed {
        logic [2:0][32:0] cum;
    } pow_stage_t;

    // Restoring division stages, three numerators over one total.
    typedef struct packed {
        logic [2:0][32:0] rem;
        logic [2:0][16:0] quo;
        logic [2:0]       ovf;
        logic [32:0]      total;
        logic             degen;
    } div_stage_t;

    // Square root chain of one half: r(n) = 2^(-2^-n) in Q0.32, evaluated at elaboration.
    function automatic logic [31:0] exp_root(input int unsigned n);
        logic [63:0] r;
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bt;
        r = 64'h8000_0000;
        for (int unsigned k = 0; k < n; k++) begin
            v   = r << 32;
            res = '0;
            bt  = 64'h4000_0000_0000_0000;
            for (int s = 0; s < 32; s++) begin
                if (v >= res + bt) begin
                    v   = v - (res + bt);
                    res = (res >> 1) + bt;
                end else begin
                    res = res >> 1;
                end
                bt = bt >> 2;
            end
            r = res;
        end
        return r[31:0];
    endfunction

endpackage

>>> rtl/root_fraction_exponential_profile_core.sv
// Registers from input to m_data: entry, log, lgt, exp setup, exp, pow, div and output.
// Throughput: one item per cycle while the skid register is empty; 24 squaring stages
// for log2, 24 multiply stages for exp2 and 16 restoring division stages set the pipeline depth.
// A skid register parks a result behind a held output and stalls the pipeline while full.
// Reset: aresetn is synchronous and active low; it clears all valid bits, payload holds.
// Top level of the root fraction exponential profile core.
module root_fraction_exponential_profile_core import rfep_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  rfep_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output rfep_out_t m_data
);

    logic adv;
    logic skid_valid_reg;
    rfep_out_t skid_reg;
    logic m_valid_reg;
    rfep_out_t m_data_reg;

    // The whole pipeline advances while the skid register is empty.
    assign adv     = ~skid_valid_reg;
    assign s_ready = adv;

    // ------------------------------------------------------------------
    // Entry: depth sums, leading one of the coefficient and normalization.
    log_stage_t entry_next;
    always_comb begin
        logic [3:0] m;
        m = '0;
        for (int i = 0; i < FRAC_BITS; i++) begin
            if (s_data.root_coeff[i]) begin
                m = 4'(i);
            end
        end
        entry_next.dep_a      = s_data.top_depth;
        entry_next.dep_b      = 17'(s_data.top_depth) + 17'(s_data.mid_depth);
        entry_next.dep_c      = 18'(s_data.top_depth) + 18'(s_data.mid_depth)
                              + 18'(s_data.low_depth);
        entry_next.coeff_zero = (s_data.root_coeff == '0);
        entry_next.msb        = m;
        entry_next.x          = 31'(s_data.root_coeff) << (5'd30 - {1'b0, m});
        entry_next.q          = '0;
    end

    log_stage_t log_reg [0:LOG_FRAC];
    logic log_vld_reg [0:LOG_FRAC];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            log_vld_reg[0] <= 1'b0;
        end else if (adv) begin
            log_vld_reg[0] <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            log_reg[0] <= entry_next;
        end
    end

    // Each log stage squares x and takes one fraction bit of log2.
    for (genvar j = 0; j < LOG_FRAC; j++) begin : g_log
        log_stage_t log_next;
        logic [61:0] sq;
        always_comb begin
            sq       = 62'(log_reg[j].x) * 62'(log_reg[j].x);
            log_next = log_reg[j];
            if (sq[61]) begin
                log_next.x = sq[61:31];
                log_next.q = {log_reg[j].q[22:0], 1'b1};
            end else begin
                log_next.x = sq[60:30];
                log_next.q = {log_reg[j].q[22:0], 1'b0};
            end
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                log_vld_reg[j+1] <= 1'b0;
            end else if (adv) begin
                log_vld_reg[j+1] <= log_vld_reg[j];
            end
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                log_reg[j+1] <= log_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Negative logarithm L = (FRAC_BITS - m) * 2^24 - q.
    lgt_stage_t lgt_next;
    lgt_stage_t lgt_reg;
    logic lgt_vld_reg;

    always_comb begin
        lgt_next.dep_a      = log_reg[LOG_FRAC].dep_a;
        lgt_next.dep_b      = log_reg[LOG_FRAC].dep_b;
        lgt_next.dep_c      = log_reg[LOG_FRAC].dep_c;
        lgt_next.coeff_zero = log_reg[LOG_FRAC].coeff_zero;
        lgt_next.neg_log    = {5'(5'(FRAC_BITS) - {1'b0, log_reg[LOG_FRAC].msb}), 24'b0}
                            - {5'b0, log_reg[LOG_FRAC].q};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lgt_vld_reg <= 1'b0;
        end else if (adv) begin
            lgt_vld_reg <= log_vld_reg[LOG_FRAC];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            lgt_reg <= lgt_next;
        end
    end

    // ------------------------------------------------------------------
    // Exponent E = D * L / 16, split into integer and fraction parts per lane.
    exp_stage_t exp_setup_next;
    always_comb begin
        logic [2:0][17:0] dsum;
        logic [46:0] prod;
        logic [18:0] k;
        dsum[0] = {2'b0, lgt_reg.dep_a};
        dsum[1] = {1'b0, lgt_reg.dep_b};
        dsum[2] = lgt_reg.dep_c;
        for (int l = 0; l < 3; l++) begin
            prod = 47'(dsum[l]) * 47'(lgt_reg.neg_log);
            k    = prod[46:28];
            exp_setup_next.acc[l]        = ONE_Q32;
            exp_setup_next.frac[l]       = prod[27:4];
            exp_setup_next.shift[l]      = k[5:0];
            exp_setup_next.force_one[l]  = (dsum[l] == '0);
            exp_setup_next.force_zero[l] = lgt_reg.coeff_zero || (k > 19'd32);
        end
    end

    exp_stage_t exp_reg [0:LOG_FRAC];
    logic exp_vld_reg [0:LOG_FRAC];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_vld_reg[0] <= 1'b0;
        end else if (adv) begin
            exp_vld_reg[0] <= lgt_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            exp_reg[0] <= exp_setup_next;
        end
    end

    // Each exp stage multiplies in one root of two where its fraction bit is set.
    for (genvar i = 0; i < LOG_FRAC; i++) begin : g_exp
        localparam logic [31:0] ROOT = exp_root(i + 1);
        exp_stage_t exp_next;
        always_comb begin
            logic [64:0] prod;
            exp_next = exp_reg[i];
            for (int l = 0; l < 3; l++) begin
                prod = 65'(exp_reg[i].acc[l]) * 65'(ROOT);
                if (exp_reg[i].frac[l][LOG_FRAC-1-i]) begin
                    exp_next.acc[l] = prod[64:32];
                end
            end
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                exp_vld_reg[i+1] <= 1'b0;
            end else if (adv) begin
                exp_vld_reg[i+1] <= exp_vld_reg[i];
            end
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                exp_reg[i+1] <= exp_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Power and cumulative share c = 1 - P for each lane.
    pow_stage_t pow_next;
    pow_stage_t pow_reg;
    logic pow_vld_reg;

    always_comb begin
        logic [32:0] p;
        for (int l = 0; l < 3; l++) begin
            if (exp_reg[LOG_FRAC].force_one[l]) begin
                p = ONE_Q32;
            end else if (exp_reg[LOG_FRAC].force_zero[l]) begin
                p = '0;
            end else begin
                p = exp_reg[LOG_FRAC].acc[l] >> exp_reg[LOG_FRAC].shift[l];
            end
            pow_next.cum[l] = ONE_Q32 - p;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pow_vld_reg <= 1'b0;
        end else if (adv) begin
            pow_vld_reg <= exp_vld_reg[LOG_FRAC];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pow_reg <= pow_next;
        end
    end

    // ------------------------------------------------------------------
    // Division setup: layer numerators, overflow test and the integer quotient bit.
    div_stage_t div_setup_next;
    always_comb begin
        logic [2:0][32:0] num;
        logic [32:0] total;
        logic q16;
        total  = pow_reg.cum[2];
        num[0] = pow_reg.cum[0];
        num[1] = (pow_reg.cum[1] > pow_reg.cum[0]) ? pow_reg.cum[1] - pow_reg.cum[0] : '0;
        num[2] = (pow_reg.cum[2] > pow_reg.cum[1]) ? pow_reg.cum[2] - pow_reg.cum[1] : '0;
        div_setup_next.total = total;
        div_setup_next.degen = (total == '0);
        for (int l = 0; l < 3; l++) begin
            q16 = (num[l] >= total);
            div_setup_next.ovf[l] = ({1'b0, num[l]} >= {total, 1'b0});
            div_setup_next.rem[l] = q16 ? num[l] - total : num[l];
            div_setup_next.quo[l] = {16'b0, q16};
        end
    end

    div_stage_t div_reg [0:DIV_STEPS];
    logic div_vld_reg [0:DIV_STEPS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_vld_reg[0] <= 1'b0;
        end else if (adv) begin
            div_vld_reg[0] <= pow_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            div_reg[0] <= div_setup_next;
        end
    end

    // Each division stage produces one fraction bit of the quotient.
    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
        div_stage_t div_next;
        always_comb begin
            logic [33:0] t;
            logic ge;
            div_next = div_reg[j];
            for (int l = 0; l < 3; l++) begin
                t  = {div_reg[j].rem[l], 1'b0};
                ge = (t >= {1'b0, div_reg[j].total});
                div_next.rem[l] = ge ? 33'(t - {1'b0, div_reg[j].total}) : t[32:0];
                div_next.quo[l] = {div_reg[j].quo[l][15:0], ge};
            end
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                div_vld_reg[j+1] <= 1'b0;
            end else if (adv) begin
                div_vld_reg[j+1] <= div_vld_reg[j];
            end
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                div_reg[j+1] <= div_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Saturation to 1.0 and the zero-total case.
    rfep_out_t res_next;
    always_comb begin
        logic [2:0][16:0] sh;
        for (int l = 0; l < 3; l++) begin
            if (div_reg[DIV_STEPS].degen) begin
                sh[l] = '0;
            end else if (div_reg[DIV_STEPS].ovf[l] || div_reg[DIV_STEPS].quo[l] > SHARE_ONE) begin
                sh[l] = SHARE_ONE;
            end else begin
                sh[l] = div_reg[DIV_STEPS].quo[l];
            end
        end
        res_next.share_top  = sh[0];
        res_next.share_mid  = sh[1];
        res_next.share_low  = sh[2];
        res_next.degenerate = div_reg[DIV_STEPS].degen;
    end

    // Output register with skid: a result that meets a held output parks in the skid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!m_valid_reg || m_ready) begin
            m_valid_reg    <= skid_valid_reg || div_vld_reg[DIV_STEPS];
            skid_valid_reg <= 1'b0;
        end else if (adv && div_vld_reg[DIV_STEPS]) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_valid_reg || m_ready) begin
            m_data_reg <= skid_valid_reg ? skid_reg : res_next;
        end else if (adv && div_vld_reg[DIV_STEPS]) begin
            skid_reg <= res_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
